### rtl/tic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tic_pkg
// Shared types and constants for the titration injection concentration block.
// ----------------------------------------------------------------------------
package tic_pkg;

    localparam int unsigned SHOT_W    = 24;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] PROD_ONE = 32'h8000_0000;
    localparam logic [WORD_W-1:0] SAT32    = 32'hFFFF_FFFF;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOTCFG = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_VOLUME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_CONC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYRINGE_CONC = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONST_VOLUME = 2'd3;

    typedef struct packed {
        logic                  valid;
        logic [2*WORD_W-1:0]   dividend;
        logic [WORD_W-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

### rtl/tic_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tic_if
// Valid/ready channels: injection input, result output, register writes.
// ----------------------------------------------------------------------------
interface tic_in_if;
    logic                      valid;
    logic                      ready;
    logic [tic_pkg::SHOT_W-1:0] shot_volume;
    logic                      start_req;

    modport source(output valid, output shot_volume, output start_req, input ready);
    modport sink(input valid, input shot_volume, input start_req, output ready);
endinterface

interface tic_out_if;
    logic                       valid;
    logic                       ready;
    logic [tic_pkg::WORD_W-1:0] volume_out;
    logic [tic_pkg::WORD_W-1:0] host_concentration;
    logic [tic_pkg::WORD_W-1:0] guest_concentration;
    logic [1:0]                 status;
    logic                       corrupt_seen;

    modport source(output valid, output volume_out, output host_concentration,
                   output guest_concentration, output status, output corrupt_seen,
                   input ready);
    modport sink(input valid, input volume_out, input host_concentration,
                 input guest_concentration, input status, input corrupt_seen,
                 output ready);
endinterface

interface tic_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tic_pkg::CFG_IDX_W-1:0] index;
    logic [tic_pkg::WORD_W-1:0]    data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/tic_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tic_div
// Restoring 64/32 divider, one quotient bit per cycle. Caller guarantees the
// upper dividend word is below the divisor, so the quotient fits 32 bits.
// ----------------------------------------------------------------------------
module tic_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tic_pkg::t_div_req i_req,
    output tic_pkg::t_div_rsp      o_rsp
);

    localparam int unsigned W = tic_pkg::WORD_W;

    logic         r_busy;
    logic         r_done;
    logic [4:0]   r_cnt;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_lo;
    logic [W-1:0] r_den;

    logic [W+1:0] trial;
    logic         ge;

    assign trial = {1'b0, r_rem, r_lo[W-1]} - {2'b00, r_den};
    assign ge    = ~trial[W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.valid) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_rem <= i_req.dividend[2*W-1:W];
            r_lo  <= i_req.dividend[W-1:0];
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? trial[W-1:0] : {r_rem[W-2:0], r_lo[W-1]};
            r_lo  <= {r_lo[W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_lo;

endmodule
`default_nettype wire

### rtl/titration_injection_concentrations.sv
`default_nettype none
// ----------------------------------------------------------------------------
// titration_injection_concentrations
// Per-injection cell volume and host/guest totals for a titration cell, with
// constant-volume (overflow) and growing-volume dilution models.
// ----------------------------------------------------------------------------
//  channel  dir  port   beat
//  -------  ---  -----  ----------------------------------------------------
//  input    in   i_in   shot_volume, start_req
//  result   out  o_out  volume_out, host/guest_concentration, status, corrupt
//  config   in   i_cfg  index, data (always ready)
//
//  Work per beat falls on the shared divider (one pass for the factor, skipped
//  for an oversize shot; two more passes when the volume grows) and on the
//  single shared 32x32 multiplier; an unconfigured beat uses neither.
//  Synchronous active-low reset clears settings, running state and output valid
//  and selects constant-volume mode; result data registers are not reset.
//  A finished result sits in the output register; a new beat is taken meanwhile.
//  The next result then holds in S_FIN until the output register drains.
module titration_injection_concentrations (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tic_in_if.sink     i_in,
    tic_out_if.source  o_out,
    tic_cfg_if.sink    i_cfg
);

    localparam int unsigned W = tic_pkg::WORD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_WFAC, S_SUM, S_MP, S_MDH, S_UPD, S_MG, S_GC,
        S_VC, S_DH, S_WH, S_MGS, S_DG, S_WG, S_FIN
    } t_state;

    t_state r_state;

    logic [W-1:0] r_v0, r_c0, r_cs;
    logic         r_cv;

    logic [tic_pkg::SHOT_W-1:0] r_shot;
    logic [W-1:0] r_inj, r_p, r_dh, r_fac, r_vc;
    logic         r_corrupt;
    logic [W-1:0] r_vol, r_host, r_guest;
    logic [1:0]   r_stat;

    logic         r_out_valid;
    logic [W-1:0] r_o_vol, r_o_host, r_o_guest;
    logic [1:0]   r_o_stat;
    logic         r_o_corrupt;

    logic [2*W-1:0] r_prod;
    logic [W-1:0]   mul_a, mul_b;
    logic [2*W-1:0] mul_p;

    tic_pkg::t_div_req div_req;
    tic_pkg::t_div_rsp div_rsp;

    logic           in_acc;
    logic           not_cfg;
    logic           oversize;
    logic [W-1:0]   v_left;
    logic [W:0]     n_inj;
    logic [W:0]     n_vc;
    logic           out_free;

    assign in_acc   = i_in.valid & i_in.ready;
    assign not_cfg  = (r_v0 == '0) | (r_c0 == '0) | (r_cs == '0);
    assign oversize = {8'd0, r_shot} > r_v0;
    assign v_left   = r_v0 - {8'd0, r_shot};
    assign n_inj    = {1'b0, r_inj} + {9'd0, r_shot};
    assign n_vc     = {1'b0, r_v0} + {1'b0, r_inj};
    assign out_free = ~r_out_valid | o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MP: begin
                mul_a = r_p;
                mul_b = r_fac;
            end
            S_MDH: begin
                mul_a = r_dh;
                mul_b = r_fac;
            end
            S_MG: begin
                mul_a = r_cs;
                mul_b = tic_pkg::PROD_ONE - r_p;
            end
            S_VC: begin
                mul_a = r_c0;
                mul_b = r_v0;
            end
            S_MGS: begin
                mul_a = r_cs;
                mul_b = r_inj;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        div_req.valid    = 1'b0;
        div_req.dividend = r_prod;
        div_req.divisor  = r_vc;
        case (r_state)
            S_CHECK: begin
                div_req.valid    = ~not_cfg & ~oversize;
                div_req.dividend = {1'b0, v_left, 31'd0};
                div_req.divisor  = r_v0;
            end
            S_DH, S_DG: begin
                div_req.valid = 1'b1;
            end
            default: begin
                div_req.valid = 1'b0;
            end
        endcase
    end

    tic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v0        <= '0;
            r_c0        <= '0;
            r_cs        <= '0;
            r_cv        <= 1'b1;
            r_inj       <= '0;
            r_p         <= tic_pkg::PROD_ONE;
            r_dh        <= '0;
            r_corrupt   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    tic_pkg::REG_CELL_VOLUME:  r_v0 <= i_cfg.data;
                    tic_pkg::REG_CELL_CONC:    r_c0 <= i_cfg.data;
                    tic_pkg::REG_SYRINGE_CONC: r_cs <= i_cfg.data;
                    tic_pkg::REG_CONST_VOLUME: r_cv <= i_cfg.data[0];
                    default:                   r_cv <= r_cv;
                endcase
            end

            if (r_out_valid && o_out.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_shot <= i_in.shot_volume;
                        if (i_in.start_req) begin
                            r_inj     <= '0;
                            r_p       <= tic_pkg::PROD_ONE;
                            r_dh      <= r_c0;
                            r_corrupt <= 1'b0;
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (not_cfg) begin
                        r_vol   <= '0;
                        r_host  <= '0;
                        r_guest <= '0;
                        r_stat  <= tic_pkg::ST_NOTCFG;
                        r_state <= S_FIN;
                    end else if (oversize) begin
                        r_fac   <= '0;
                        r_stat  <= tic_pkg::ST_BAD;
                        r_state <= S_SUM;
                    end else begin
                        r_stat  <= tic_pkg::ST_OK;
                        r_state <= S_WFAC;
                    end
                end
                S_WFAC: begin
                    if (div_rsp.done) begin
                        r_fac   <= div_rsp.quotient;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (n_inj[W]) begin
                        r_inj  <= tic_pkg::SAT32;
                        r_stat <= tic_pkg::ST_BAD;
                    end else begin
                        r_inj <= n_inj[W-1:0];
                    end
                    r_state <= S_MP;
                end
                S_MP: begin
                    r_state <= S_MDH;
                end
                S_MDH: begin
                    r_p     <= r_prod[2*W-2:W-1];
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_dh    <= r_prod[2*W-2:W-1];
                    r_state <= r_cv ? S_MG : S_VC;
                end
                S_MG: begin
                    r_state <= S_GC;
                end
                S_GC: begin
                    r_vol   <= r_v0;
                    r_host  <= r_dh;
                    r_guest <= r_prod[2*W-2:W-1];
                    r_state <= S_FIN;
                end
                S_VC: begin
                    if (n_vc[W]) begin
                        r_vc   <= tic_pkg::SAT32;
                        r_vol  <= tic_pkg::SAT32;
                        r_stat <= tic_pkg::ST_BAD;
                    end else begin
                        r_vc  <= n_vc[W-1:0];
                        r_vol <= n_vc[W-1:0];
                    end
                    r_state <= S_DH;
                end
                S_DH: begin
                    r_state <= S_WH;
                end
                S_WH: begin
                    if (div_rsp.done) begin
                        r_host  <= div_rsp.quotient;
                        r_state <= S_MGS;
                    end
                end
                S_MGS: begin
                    r_state <= S_DG;
                end
                S_DG: begin
                    r_state <= S_WG;
                end
                S_WG: begin
                    if (div_rsp.done) begin
                        r_guest <= div_rsp.quotient;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_vol     <= r_vol;
                        r_o_host    <= r_host;
                        r_o_guest   <= r_guest;
                        r_o_stat    <= r_stat;
                        r_o_corrupt <= r_corrupt | (r_stat == tic_pkg::ST_BAD);
                        r_corrupt   <= r_corrupt | (r_stat == tic_pkg::ST_BAD);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.volume_out          = r_o_vol;
    assign o_out.host_concentration  = r_o_host;
    assign o_out.guest_concentration = r_o_guest;
    assign o_out.status              = r_o_stat;
    assign o_out.corrupt_seen        = r_o_corrupt;

`ifndef SYNTH
    a_prod_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p <= tic_pkg::PROD_ONE)
        else $error("dilution product above one");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_WFAC || r_state == S_WH || r_state == S_WG))
        else $error("divider finished outside a wait state");

    a_corrupt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_corrupt && !(in_acc && i_in.start_req) |=> r_corrupt)
        else $error("corrupt flag dropped without start");

    a_bad_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == tic_pkg::ST_BAD |-> o_out.corrupt_seen)
        else $error("bad status without corrupt flag");
`endif

endmodule
`default_nettype wire
